>>> rtl/core/gpg_pkg.sv
// gpg_pkg: shared types and constants for the binary polynomial gcd block
// used by the channel interfaces, the gcd engine and the top level

package gpg_pkg;

	localparam int FIELD_W = 64;
	localparam int DEG_W   = 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_ALIGN,
		ST_DONE
	} gpg_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} gpg_stat_t;

endpackage

>>> rtl/core/gpg_if.sv
// gpg_if: valid/ready channel interfaces for operand and result items
// depends on gpg_pkg for the field widths

interface gpg_in_if import gpg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] poly_a;
	logic [FIELD_W-1:0] poly_b;

	modport source (output valid, output poly_a, output poly_b, input ready);
	modport sink (input valid, input poly_a, input poly_b, output ready);
endinterface

interface gpg_out_if import gpg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] gcd_poly;
	logic [DEG_W-1:0]   gcd_degree;

	modport source (output valid, output gcd_poly, output gcd_degree, input ready);
	modport sink (input valid, input gcd_poly, input gcd_degree, output ready);
endinterface

>>> rtl/core/gpg_core.sv
// gpg_core: bit-serial euclidean gcd engine over left-aligned operands
// depends on gpg_pkg for the state and status types

module gpg_core import gpg_pkg::*; #(
	parameter int POLY_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          ack,
	input  logic [POLY_WIDTH-1:0]         op_a,
	input  logic [POLY_WIDTH-1:0]         op_b,
	output gpg_stat_t                     stat,
	output logic [POLY_WIDTH-1:0]         res_poly,
	output logic [$clog2(POLY_WIDTH)-1:0] res_deg
);

	localparam int DW = $clog2(POLY_WIDTH);
	localparam int TOP = POLY_WIDTH - 1;
	localparam logic [DW-1:0] MAXD = DW'(POLY_WIDTH - 1);

	gpg_state_t state_q, state_d;

	logic [POLY_WIDTH-1:0] a_q, b_q;
	logic [DW-1:0]         da_q, db_q, sh_q;

	logic a_top, b_top, za, zb;
	logic fin, pick_b, shift_a, shift_b, do_xor;

	// a register holds its polynomial shifted up so that x^deg sits at the top bit
	assign a_top = a_q[TOP];
	assign b_top = b_q[TOP];
	assign za    = !a_top && (da_q == '0);
	assign zb    = !b_top && (db_q == '0);

	always_comb begin
		fin     = 1'b0;
		pick_b  = 1'b0;
		if (za && (zb || b_top)) begin
			fin    = 1'b1;
			pick_b = 1'b1;
		end else if (zb && a_top) begin
			fin    = 1'b1;
		end
		shift_a = !a_top && !za;
		shift_b = !b_top && !zb;
		do_xor  = a_top && b_top;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (fin) state_d = ST_ALIGN;
			end
			ST_ALIGN: begin
				if (sh_q == '0) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (ack) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					a_q  <= op_a;
					b_q  <= op_b;
					da_q <= MAXD;
					db_q <= MAXD;
				end
			end
			ST_RUN: begin
				if (fin) begin
					a_q  <= pick_b ? b_q : a_q;
					da_q <= pick_b ? db_q : da_q;
					sh_q <= MAXD - (pick_b ? db_q : da_q);
				end else begin
					if (shift_a) begin
						a_q  <= a_q << 1;
						da_q <= da_q - 1'b1;
					end
					if (shift_b) begin
						b_q  <= b_q << 1;
						db_q <= db_q - 1'b1;
					end
					if (do_xor) begin
						if (da_q >= db_q) begin
							a_q <= a_q ^ b_q;
						end else begin
							b_q <= b_q ^ a_q;
						end
					end
				end
			end
			ST_ALIGN: begin
				if (sh_q != '0) begin
					a_q  <= a_q >> 1;
					sh_q <= sh_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign res_poly  = a_q;
	assign res_deg   = da_q;

endmodule

>>> rtl/core/gf2_polynomial_gcd.sv
// gf2_polynomial_gcd: greatest common divisor of two binary polynomials
// depends on gpg_pkg, gpg_if and gpg_core
//
// usage: operand items arrive on in_ch (poly_a, poly_b, bit i is the x^i
// coefficient); one result item per operand item leaves on out_ch with
// gcd_poly and its degree gcd_degree. bits at and above POLY_WIDTH are ignored.
// a zero operand yields the other operand; two zero operands yield zero.
// the engine takes one item at a time: in_ch.ready is high while it is idle,
// so the next item can be taken once a result has entered the output register.
// each cycle it either shifts the unaligned operands up by one bit or xors the
// aligned operands, then shifts the gcd back down one bit per cycle.
// the result sits in an output register; a new item is accepted while it waits.
// when the receiver stalls and the next gcd is ready, the engine holds it
// until the output register frees up.
// reset clears the engine state and the output valid; no item is in flight.

module gf2_polynomial_gcd import gpg_pkg::*; #(
	parameter int POLY_WIDTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	gpg_in_if.sink   in_ch,
	gpg_out_if.source out_ch
);

	localparam int DW = $clog2(POLY_WIDTH);

	gpg_stat_t             stat;
	logic                  start, ack;
	logic [POLY_WIDTH-1:0] res_poly;
	logic [DW-1:0]         res_deg;

	logic                  out_valid_q;
	logic [FIELD_W-1:0]    gcd_poly_q;
	logic [DEG_W-1:0]      gcd_degree_q;

	assign in_ch.ready = !stat.busy;
	assign start       = in_ch.valid && !stat.busy;
	assign ack         = stat.done && (!out_valid_q || out_ch.ready);

	gpg_core #(
		.POLY_WIDTH(POLY_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.ack      (ack),
		.op_a     (in_ch.poly_a[POLY_WIDTH-1:0]),
		.op_b     (in_ch.poly_b[POLY_WIDTH-1:0]),
		.stat     (stat),
		.res_poly (res_poly),
		.res_deg  (res_deg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			gcd_poly_q   <= FIELD_W'(res_poly);
			gcd_degree_q <= DEG_W'(res_deg);
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.gcd_poly   = gcd_poly_q;
	assign out_ch.gcd_degree = gcd_degree_q;

endmodule

>>> rtl/core/gpg_checker.sv
// gpg_checker: port-level checks on the gcd block over time
// depends on gpg_pkg; bound to gf2_polynomial_gcd at the end of this file

module gpg_checker import gpg_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [FIELD_W-1:0] gcd_poly,
	input logic [DEG_W-1:0]   gcd_degree
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gcd_poly) && $stable(gcd_degree))
		else $error("result changed while stalled");

	// reported degree is the top set bit of the gcd, or zero for a zero gcd
	a_deg_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((gcd_poly >> gcd_degree) == 64'd1) ||
			((gcd_poly == '0) && (gcd_degree == '0)))
		else $error("gcd degree does not match gcd");

	// one item at a time in the engine
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while engine busy");

	// a result never appears the cycle after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

endmodule

bind gf2_polynomial_gcd gpg_checker u_gpg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.gcd_poly   (out_ch.gcd_poly),
	.gcd_degree (out_ch.gcd_degree)
);
